// ===== rtl/lpc_pkg.sv =====
`timescale 1ns / 1ps

package lpc_pkg;

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LO   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HI   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_HI = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LO  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_HI  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_XY   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Z    = 4'd7;
    localparam int CFG_DATA_W = 64;

    localparam int DEF_COORD_WIDTH      = 16;
    localparam int DEF_ANGLE_ITERATIONS = 16;

    localparam int BOUND_W   = 16;
    localparam int AZ_W      = 12;
    localparam int KEPT_W    = 16;
    localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

    // angle accumulator: 1/256 of a tenth of a degree
    localparam int ACC_W         = 22;
    localparam int ANG_TAB_W     = 17;
    localparam int ANG_IDX_W     = 5;
    localparam int ANG_HALF_TURN = 1800 * 256;
    localparam int AZ_LIMIT      = 1800;
    localparam int ROUND_HALF    = 128;

    // squaring sequence steps
    localparam int SQ_W = 3;
    localparam logic [SQ_W-1:0] SQ_AX   = 3'd0;
    localparam logic [SQ_W-1:0] SQ_AY   = 3'd1;
    localparam logic [SQ_W-1:0] SQ_LO   = 3'd2;
    localparam logic [SQ_W-1:0] SQ_HI   = 3'd3;
    localparam logic [SQ_W-1:0] SQ_LAST = 3'd4;
    localparam logic [SQ_W-1:0] SQ_DONE = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN,
        ST_DEC
    } lpc_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } lpc_ctl_t;

    // round(atan(2^-i) * 2560 * 180 / pi)
    function automatic logic [ANG_TAB_W-1:0] ang_tab(input logic [ANG_IDX_W-1:0] i);
        logic [ANG_TAB_W-1:0] v;
        unique case (i)
            5'd0:    v = 17'd115200;
            5'd1:    v = 17'd68007;
            5'd2:    v = 17'd35933;
            5'd3:    v = 17'd18240;
            5'd4:    v = 17'd9155;
            5'd5:    v = 17'd4582;
            5'd6:    v = 17'd2292;
            5'd7:    v = 17'd1146;
            5'd8:    v = 17'd573;
            5'd9:    v = 17'd286;
            5'd10:   v = 17'd143;
            5'd11:   v = 17'd72;
            5'd12:   v = 17'd36;
            5'd13:   v = 17'd18;
            5'd14:   v = 17'd9;
            5'd15:   v = 17'd4;
            5'd16:   v = 17'd2;
            5'd17:   v = 17'd1;
            5'd18:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/lpc_if.sv =====
`timescale 1ns / 1ps

interface lpc_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic                          cloud_end;

    modport source (output valid, px, py, pz, cloud_end, input ready);
    modport sink   (input valid, px, py, pz, cloud_end, output ready);
endinterface

interface lpc_out_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          keep;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic [15:0]                   kept_total;
    logic                          out_end;

    modport source (output valid, keep, out_x, out_y, out_z, kept_total, out_end,
                    input ready);
    modport sink   (input valid, keep, out_x, out_y, out_z, kept_total, out_end,
                    output ready);
endinterface

// ===== rtl/lidar_point_range_crop_filter.sv =====
`timescale 1ns / 1ps

// Lidar point crop filter.
//
// pt_in takes one point word (px, py, pz, cloud_end); pt_out gives one result
// word per point (keep, out_x/y/z, kept_total, out_end). cfg_we/cfg_index/
// cfg_data write the bound and robot-box registers; write only while idle.
// Indexes past the last register are dropped.
//
// Each point passes through the states in order: the idle state takes the
// point, the iterative arctangent then runs one vectoring step per cycle,
// a finish state rounds the angle and a decide state compares. The squarer
// shares the step cycles, one product per cycle. A result becomes valid when
// the block returns to idle, and pt_in is ready again in that same cycle.
//
// The output word sits in a register, so a new point is taken and worked on
// while a result still waits; if pt_out is still stalled when the next result
// is ready, the block holds it in the compare step.
// Reset restores the register defaults, clears the kept count, empties the
// output register and leaves the block ready.
module lidar_point_range_crop_filter
    import lpc_pkg::*;
#(
    parameter int COORD_WIDTH      = DEF_COORD_WIDTH,
    parameter int ANGLE_ITERATIONS = DEF_ANGLE_ITERATIONS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lpc_in_if.sink                pt_in,
    lpc_out_if.source             pt_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MW = (COORD_WIDTH > BOUND_W) ? COORD_WIDTH : BOUND_W;
    localparam int DW = 2 * MW + 1;

    // configuration registers
    logic [BOUND_W-1:0]        range_lo_reg, range_hi_reg;
    logic signed [AZ_W-1:0]    azimuth_lo_reg, azimuth_hi_reg;
    logic signed [BOUND_W-1:0] height_lo_reg, height_hi_reg;
    logic [63:0]               robot_xy_reg;
    logic [31:0]               robot_z_reg;

    // sequencer and point hold
    lpc_state_t state_reg, state_next;
    lpc_ctl_t   ctl;
    logic       load_out;

    logic signed [COORD_WIDTH-1:0] px_reg, py_reg, pz_reg;
    logic                          end_reg;
    logic [KEPT_W-1:0]             kept_reg, kept_inc;

    // output word register
    logic                          out_valid_reg;
    logic                          out_keep_reg, out_end_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [KEPT_W-1:0]             out_kept_reg;

    // unit results
    logic                   cordic_last, sq_done;
    logic signed [AZ_W-1:0] az;
    logic [DW-1:0]          d2, lo_sq, hi_sq;

    logic signed [MW-1:0] xe, ye, ze;
    logic in_range, in_box, keep;

    lpc_cordic #(
        .COORD_WIDTH      (COORD_WIDTH),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .x     (pt_in.px),
        .y     (pt_in.py),
        .last  (cordic_last),
        .az    (az)
    );

    lpc_sqmul #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqmul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .x     (pt_in.px),
        .y     (pt_in.py),
        .lo    (range_lo_reg),
        .hi    (range_hi_reg),
        .done  (sq_done),
        .d2    (d2),
        .lo_sq (lo_sq),
        .hi_sq (hi_sq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lo_reg   <= 16'd0;
            range_hi_reg   <= 16'd3000;
            azimuth_lo_reg <= -12'sd1800;
            azimuth_hi_reg <= 12'sd1800;
            height_lo_reg  <= 16'sd30;
            height_hi_reg  <= 16'sd150;
            robot_xy_reg   <= 64'd28428543157665692;
            robot_z_reg    <= 32'd6619036;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RANGE_LO:   range_lo_reg   <= cfg_data[15:0];
                CFG_RANGE_HI:   range_hi_reg   <= cfg_data[15:0];
                CFG_AZIMUTH_LO: azimuth_lo_reg <= $signed(cfg_data[11:0]);
                CFG_AZIMUTH_HI: azimuth_hi_reg <= $signed(cfg_data[11:0]);
                CFG_HEIGHT_LO:  height_lo_reg  <= $signed(cfg_data[15:0]);
                CFG_HEIGHT_HI:  height_hi_reg  <= $signed(cfg_data[15:0]);
                CFG_ROBOT_XY:   robot_xy_reg   <= cfg_data;
                CFG_ROBOT_Z:    robot_z_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // tests, all bounds inclusive; an empty band fails everything
    always_comb
    begin
        xe = MW'(px_reg);
        ye = MW'(py_reg);
        ze = MW'(pz_reg);
        in_range = (d2 >= lo_sq) && (d2 <= hi_sq)
                && (az >= azimuth_lo_reg) && (az <= azimuth_hi_reg)
                && (ze >= MW'(height_lo_reg)) && (ze <= MW'(height_hi_reg));
        in_box   = (xe >= MW'($signed(robot_xy_reg[15:0])))
                && (xe <= MW'($signed(robot_xy_reg[31:16])))
                && (ye >= MW'($signed(robot_xy_reg[47:32])))
                && (ye <= MW'($signed(robot_xy_reg[63:48])))
                && (ze >= MW'($signed(robot_z_reg[15:0])))
                && (ze <= MW'($signed(robot_z_reg[31:16])));
        keep     = in_range && !in_box;
        // count saturates at the top
        kept_inc = (keep && (kept_reg != KEPT_MAX)) ? kept_reg + 1'b1 : kept_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        load_out    = 1'b0;
        pt_in.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pt_in.ready = 1'b1;
                if (pt_in.valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
                if (cordic_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                ctl.finish = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                // wait here while the previous word is still held
                if (!out_valid_reg || pt_out.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                kept_reg      <= end_reg ? '0 : kept_inc;
                out_valid_reg <= 1'b1;
            end
            else if (pt_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            px_reg  <= pt_in.px;
            py_reg  <= pt_in.py;
            pz_reg  <= pt_in.pz;
            end_reg <= pt_in.cloud_end;
        end
        if (load_out)
        begin
            out_keep_reg <= keep;
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_z_reg    <= pz_reg;
            out_kept_reg <= kept_inc;
            out_end_reg  <= end_reg;
        end
    end

    assign pt_out.valid      = out_valid_reg;
    assign pt_out.keep       = out_keep_reg;
    assign pt_out.out_x      = out_x_reg;
    assign pt_out.out_y      = out_y_reg;
    assign pt_out.out_z      = out_z_reg;
    assign pt_out.kept_total = out_kept_reg;
    assign pt_out.out_end    = out_end_reg;

    // squares must be settled before the angle is rounded
    a_sq_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> sq_done)
        else $error("squarer not finished at angle rounding");

    // no point taken while one is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pt_in.ready)
        else $error("input ready while busy");

    // count clears after the last word of a cloud
    a_cloud_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && end_reg) |=> (kept_reg == '0))
        else $error("kept count not cleared at cloud end");

    // a held word is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || pt_out.ready))
        else $error("output word overwritten");

endmodule

// ===== rtl/lpc_cordic.sv =====
`timescale 1ns / 1ps

module lpc_cordic
    import lpc_pkg::*;
#(
    parameter int COORD_WIDTH      = DEF_COORD_WIDTH,
    parameter int ANGLE_ITERATIONS = DEF_ANGLE_ITERATIONS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpc_ctl_t                      ctl,
    input  logic signed [COORD_WIDTH-1:0] x,
    input  logic signed [COORD_WIDTH-1:0] y,
    output logic                          last,
    output logic signed [AZ_W-1:0]        az
);

    // scaled by 2^16, plus headroom for negation and CORDIC gain
    localparam int CW = COORD_WIDTH + 19;
    localparam int IW = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;

    logic signed [CW-1:0]    xs_reg, ys_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [IW-1:0]           cnt_reg;
    logic                    origin_reg;
    logic signed [AZ_W-1:0]  az_reg;

    logic signed [CW-1:0]    xl, yl, dx, dy;
    logic signed [ACC_W-1:0] tab, rnd, half;

    always_comb
    begin
        xl   = $signed({{(CW-COORD_WIDTH-16){x[COORD_WIDTH-1]}}, x, 16'b0});
        yl   = $signed({{(CW-COORD_WIDTH-16){y[COORD_WIDTH-1]}}, y, 16'b0});
        dx   = ys_reg >>> cnt_reg;
        dy   = xs_reg >>> cnt_reg;
        tab  = $signed({{(ACC_W-ANG_TAB_W){1'b0}}, ang_tab(ANG_IDX_W'(cnt_reg))});
        half = ACC_W'(ANG_HALF_TURN);
        rnd  = (acc_reg + ACC_W'(ROUND_HALF)) >>> 8;
    end

    assign last = (cnt_reg == IW'(ANGLE_ITERATIONS - 1));
    assign az   = az_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.load)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.step && !last)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            origin_reg <= (x == '0) && (y == '0);
            if (x[COORD_WIDTH-1])
            begin
                xs_reg  <= -xl;
                ys_reg  <= -yl;
                acc_reg <= y[COORD_WIDTH-1] ? -half : half;
            end
            else
            begin
                xs_reg  <= xl;
                ys_reg  <= yl;
                acc_reg <= '0;
            end
        end
        else if (ctl.step)
        begin
            // y == 0 counts as non-negative
            if (!ys_reg[CW-1])
            begin
                xs_reg  <= xs_reg + dx;
                ys_reg  <= ys_reg - dy;
                acc_reg <= acc_reg + tab;
            end
            else
            begin
                xs_reg  <= xs_reg - dx;
                ys_reg  <= ys_reg + dy;
                acc_reg <= acc_reg - tab;
            end
        end

        if (ctl.finish)
        begin
            if (origin_reg)
                az_reg <= '0;
            else if (rnd > ACC_W'(AZ_LIMIT))
                az_reg <= AZ_W'(AZ_LIMIT);
            else if (rnd < -ACC_W'(AZ_LIMIT))
                az_reg <= -AZ_W'(AZ_LIMIT);
            else
                az_reg <= AZ_W'(rnd);
        end
    end

endmodule

// ===== rtl/lpc_sqmul.sv =====
`timescale 1ns / 1ps

module lpc_sqmul
    import lpc_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    localparam int MW = (COORD_WIDTH > BOUND_W) ? COORD_WIDTH : BOUND_W,
    localparam int DW = 2 * MW + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpc_ctl_t                      ctl,
    input  logic signed [COORD_WIDTH-1:0] x,
    input  logic signed [COORD_WIDTH-1:0] y,
    input  logic [BOUND_W-1:0]            lo,
    input  logic [BOUND_W-1:0]            hi,
    output logic                          done,
    output logic [DW-1:0]                 d2,
    output logic [DW-1:0]                 lo_sq,
    output logic [DW-1:0]                 hi_sq
);

    localparam int PW = 2 * MW;

    logic [SQ_W-1:0]        cnt_reg;
    logic [MW-1:0]          ax_reg, ay_reg, lo_reg, hi_reg, op;
    logic [PW-1:0]          prod_reg;
    logic [DW-1:0]          d2_reg, lo_sq_reg, hi_sq_reg;
    logic [COORD_WIDTH-1:0] ax, ay;

    assign ax    = x[COORD_WIDTH-1] ? COORD_WIDTH'(-x) : COORD_WIDTH'(x);
    assign ay    = y[COORD_WIDTH-1] ? COORD_WIDTH'(-y) : COORD_WIDTH'(y);
    assign done  = (cnt_reg == SQ_DONE);
    assign d2    = d2_reg;
    assign lo_sq = lo_sq_reg;
    assign hi_sq = hi_sq_reg;

    // one squarer, operand picked by step
    always_comb
    begin
        case (cnt_reg)
            SQ_AX:   op = ax_reg;
            SQ_AY:   op = ay_reg;
            SQ_LO:   op = lo_reg;
            SQ_HI:   op = hi_reg;
            default: op = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= SQ_DONE;
        else if (ctl.load)
            cnt_reg <= SQ_AX;
        else if (ctl.step && !done)
            cnt_reg <= cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ax_reg <= MW'(ax);
            ay_reg <= MW'(ay);
            lo_reg <= MW'(lo);
            hi_reg <= MW'(hi);
        end
        else if (ctl.step && !done)
        begin
            prod_reg <= op * op;
            case (cnt_reg)
                SQ_AY:   d2_reg    <= DW'(prod_reg);
                SQ_LO:   d2_reg    <= d2_reg + DW'(prod_reg);
                SQ_HI:   lo_sq_reg <= DW'(prod_reg);
                SQ_LAST: hi_sq_reg <= DW'(prod_reg);
                default: ;
            endcase
        end
    end

endmodule

// ===== tb/lpc_tb_pkg.sv =====
`timescale 1ns / 1ps

package lpc_tb_pkg;

    import lpc_pkg::*;

    localparam int CW           = DEF_COORD_WIDTH;
    localparam int CORDIC_STEPS = DEF_ANGLE_ITERATIONS;
    localparam int REPORT_LIMIT = 40;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_ROBOT_Z + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } point_t;

    typedef struct packed {
        logic                 keep;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [KEPT_W-1:0]    kept;
        logic                 last;
    } crop_word_t;

    class crop_scoreboard;

        logic [BOUND_W-1:0]        range_lo;
        logic [BOUND_W-1:0]        range_hi;
        logic signed [AZ_W-1:0]    az_lo;
        logic signed [AZ_W-1:0]    az_hi;
        logic signed [BOUND_W-1:0] h_lo;
        logic signed [BOUND_W-1:0] h_hi;
        logic [63:0]               xy_box;
        logic [31:0]               z_box;
        logic [KEPT_W-1:0]         kept_count;

        longint     atan_step [24];
        crop_word_t crop_words_due [$];
        int         errors;
        int         words_seen;

        function new();
            // atan(2^-i) in 1/256 of a tenth of a degree
            atan_step = '{115200, 68007, 35933, 18240, 9155, 4582, 2292, 1146,
                          573, 286, 143, 72, 36, 18, 9, 4,
                          2, 1, 1, 0, 0, 0, 0, 0};
            range_lo   = 16'd0;
            range_hi   = 16'd3000;
            az_lo      = -12'sd1800;
            az_hi      = 12'sd1800;
            h_lo       = 16'sd30;
            h_hi       = 16'sd150;
            xy_box     = {16'sd100, -16'sd100, 16'sd100, -16'sd100};
            z_box      = {16'sd100, -16'sd100};
            kept_count = '0;
            errors     = 0;
            words_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RANGE_LO:   range_lo = data[BOUND_W-1:0];
                CFG_RANGE_HI:   range_hi = data[BOUND_W-1:0];
                CFG_AZIMUTH_LO: az_lo    = data[AZ_W-1:0];
                CFG_AZIMUTH_HI: az_hi    = data[AZ_W-1:0];
                CFG_HEIGHT_LO:  h_lo     = data[BOUND_W-1:0];
                CFG_HEIGHT_HI:  h_hi     = data[BOUND_W-1:0];
                CFG_ROBOT_XY:   xy_box   = data;
                CFG_ROBOT_Z:    z_box    = data[31:0];
                default: ;
            endcase
        endfunction

        // vectoring arctangent, tenths of a degree, saturated to a half turn
        function longint azimuth_tenths(longint x, longint y);
            longint acc;
            longint xs;
            longint ys;
            longint dx;
            longint dy;
            longint az;
            int     n;
            int     i;
            acc = 0;
            if (x == 0 && y == 0)
                return 0;
            n  = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
            xs = x * 65536;
            ys = y * 65536;
            if (xs < 0)
            begin
                acc = (ys >= 0) ? ANG_HALF_TURN : -ANG_HALF_TURN;
                xs  = -xs;
                ys  = -ys;
            end
            for (i = 0; i < n; i++)
            begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys >= 0)
                begin
                    xs  = xs + dx;
                    ys  = ys - dy;
                    acc = acc + atan_step[i];
                end
                else
                begin
                    xs  = xs - dx;
                    ys  = ys + dy;
                    acc = acc - atan_step[i];
                end
            end
            az = (acc + ROUND_HALF) >>> 8;
            if (az > AZ_LIMIT)
                az = AZ_LIMIT;
            if (az < -AZ_LIMIT)
                az = -AZ_LIMIT;
            return az;
        endfunction

        function void note_point(point_t p);
            crop_word_t w;
            longint x;
            longint y;
            longint z;
            longint ax;
            longint ay;
            longint d2;
            longint rl;
            longint rh;
            longint az;
            longint bx0;
            longint bx1;
            longint by0;
            longint by1;
            longint bz0;
            longint bz1;
            logic   in_band;
            logic   on_robot;
            x   = p.x;
            y   = p.y;
            z   = p.z;
            ax  = (x < 0) ? -x : x;
            ay  = (y < 0) ? -y : y;
            d2  = ax * ax + ay * ay;
            rl  = range_lo;
            rh  = range_hi;
            az  = azimuth_tenths(x, y);
            bx0 = $signed(xy_box[15:0]);
            bx1 = $signed(xy_box[31:16]);
            by0 = $signed(xy_box[47:32]);
            by1 = $signed(xy_box[63:48]);
            bz0 = $signed(z_box[15:0]);
            bz1 = $signed(z_box[31:16]);
            in_band = d2 >= rl * rl && d2 <= rh * rh &&
                      az >= az_lo && az <= az_hi &&
                      z >= h_lo && z <= h_hi;
            on_robot = x >= bx0 && x <= bx1 && y >= by0 && y <= by1 &&
                       z >= bz0 && z <= bz1;
            w.keep = in_band && !on_robot;
            if (w.keep && kept_count != KEPT_MAX)
                kept_count = kept_count + 1'b1;
            w.x    = p.x;
            w.y    = p.y;
            w.z    = p.z;
            w.kept = kept_count;
            w.last = p.last;
            if (p.last)
                kept_count = '0;
            crop_words_due = {crop_words_due, w};
        endfunction

        task report(string msg);
            if (errors < REPORT_LIMIT)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(crop_word_t got);
            crop_word_t want;
            words_seen++;
            if (crop_words_due.size() == 0)
            begin
                report($sformatf("word %0d: result with nothing pending (x=%0d y=%0d z=%0d)",
                                 words_seen, got.x, got.y, got.z));
                return;
            end
            want = crop_words_due.pop_front();
            if (got.keep !== want.keep)
                report($sformatf("word %0d keep: got %b want %b (x=%0d y=%0d z=%0d)",
                                 words_seen, got.keep, want.keep, want.x, want.y, want.z));
            if (got.x !== want.x)
                report($sformatf("word %0d out_x: got %0d want %0d", words_seen, got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("word %0d out_y: got %0d want %0d", words_seen, got.y, want.y));
            if (got.z !== want.z)
                report($sformatf("word %0d out_z: got %0d want %0d", words_seen, got.z, want.z));
            if (got.kept !== want.kept)
                report($sformatf("word %0d kept_total: got %0d want %0d",
                                 words_seen, got.kept, want.kept));
            if (got.last !== want.last)
                report($sformatf("word %0d out_end: got %b want %b",
                                 words_seen, got.last, want.last));
        endtask

        task check_drained();
            if (crop_words_due.size() != 0)
                report($sformatf("%0d result words never arrived", crop_words_due.size()));
        endtask

        function int pending();
            return crop_words_due.size();
        endfunction

    endclass

endpackage

// ===== tb/tb_lidar_point_range_crop_filter.sv =====
`timescale 1ns / 1ps

module tb_lidar_point_range_crop_filter
    import lpc_pkg::*, lpc_tb_pkg::*;
();

    localparam int RANDOM_PER_SETTING = 92;     // 3 idle modes x 4 settings ~ 1100 words
    localparam int DRAIN_CYCLES       = CORDIC_STEPS + 8;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // idle chance in percent, per cycle, for each side
    int tx_idle_pct;
    int rx_idle_pct;

    crop_scoreboard sb = new();

    lpc_in_if  #(.COORD_WIDTH(CW)) pt_in_bus ();
    lpc_out_if #(.COORD_WIDTH(CW)) pt_out_bus ();

    lidar_point_range_crop_filter #(
        .COORD_WIDTH      (CW),
        .ANGLE_ITERATIONS (CORDIC_STEPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_in     (pt_in_bus),
        .pt_out    (pt_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Robot box packing: xmin from bit 0, then xmax, ymin, ymax.
    function automatic logic [63:0] xy_box_of(int xmin, int xmax, int ymin, int ymax);
        return {16'(ymax), 16'(ymin), 16'(xmax), 16'(xmin)};
    endfunction

    function automatic logic [31:0] z_box_of(int zmin, int zmax);
        return {16'(zmax), 16'(zmin)};
    endfunction

    // Mix of point classes: full-width noise, points around the robot box,
    // points on the axes (origin and negative x with y zero among them),
    // and a bulk of plausible scene points where the bounds actually bite.
    function automatic point_t random_point();
        point_t p;
        case ($urandom_range(9)) inside
            0, 1:
            begin
                p.x = 16'($urandom);
                p.y = 16'($urandom);
                p.z = 16'($urandom);
            end
            2:
            begin
                p.x = 16'(int'($urandom_range(1200)) - 600);
                p.y = 16'(int'($urandom_range(1200)) - 600);
                p.z = 16'(int'($urandom_range(600)) - 300);
            end
            3:
            begin
                p.x = $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(8)) - 4);
                p.y = '0;
                p.z = 16'(int'($urandom_range(400)) - 100);
                if ($urandom_range(1))
                begin
                    p.y = p.x;
                    p.x = '0;
                end
            end
            default:
            begin
                p.x = 16'(int'($urandom_range(10000)) - 5000);
                p.y = 16'(int'($urandom_range(10000)) - 5000);
                p.z = 16'(int'($urandom_range(5000)) - 2500);
            end
        endcase
        p.last = ($urandom_range(15) == 0);
        return p;
    endfunction

    // One point word. valid only drops when the sender decides to idle, so
    // back-to-back words keep it high without a second assignment per step.
    task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input logic signed [CW-1:0] z, input logic last);
        point_t p;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pt_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pt_in_bus.valid     <= 1'b1;
        pt_in_bus.px        <= x;
        pt_in_bus.py        <= y;
        pt_in_bus.pz        <= z;
        pt_in_bus.cloud_end <= last;
        do
            @(posedge clk);
        while (!pt_in_bus.ready);
        p.x    = x;
        p.y    = y;
        p.z    = z;
        p.last = last;
        sb.note_point(p);
    endtask

    // called in the step of the last handshake of a phase
    task automatic stop_sending();
        pt_in_bus.valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic load_bounds(input int rlo, input int rhi, input int alo, input int ahi,
                               input int hlo, input int hhi,
                               input logic [63:0] xy, input logic [31:0] zb);
        write_reg(CFG_RANGE_LO,   longint'(rlo));
        write_reg(CFG_RANGE_HI,   longint'(rhi));
        write_reg(CFG_AZIMUTH_LO, longint'(alo));
        write_reg(CFG_AZIMUTH_HI, longint'(ahi));
        write_reg(CFG_HEIGHT_LO,  longint'(hlo));
        write_reg(CFG_HEIGHT_HI,  longint'(hhi));
        write_reg(CFG_ROBOT_XY,   xy);
        write_reg(CFG_ROBOT_Z,    {32'd0, zb});
    endtask

    // every point gives a word, so an empty queue means the block is idle;
    // the extra cycles catch any stray word
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check on each handshake, then pick ready for the next cycle.
    initial
    begin
        crop_word_t got;
        pt_out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pt_out_bus.valid && pt_out_bus.ready)
            begin
                got.keep = pt_out_bus.keep;
                got.x    = pt_out_bus.out_x;
                got.y    = pt_out_bus.out_y;
                got.z    = pt_out_bus.out_z;
                got.kept = pt_out_bus.kept_total;
                got.last = pt_out_bus.out_end;
                sb.check_result(got);
            end
            pt_out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("lidar_point_range_crop_filter test failed");
        $finish;
    end

    initial
    begin
        int idle_tx [3];
        int idle_rx [3];
        int rlo;
        int rhi;
        point_t p;

        idle_tx = '{14, 78, 0};
        idle_rx = '{78, 14, 0};

        pt_in_bus.valid     = 1'b0;
        pt_in_bus.px        = '0;
        pt_in_bus.py        = '0;
        pt_in_bus.pz        = '0;
        pt_in_bus.cloud_end = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        rst_n               = 1'b0;
        tx_idle_pct         = idle_tx[0];
        rx_idle_pct         = idle_rx[0];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, on the reset values of every register ---
        send_point(16'sd0, 16'sd0, 16'sd50, 1'b0);            // origin, azimuth 0
        send_point(-16'sd500, 16'sd0, 16'sd100, 1'b0);        // negative x on the axis
        send_point(16'sd1000, 16'sd500, 16'sd100, 1'b0);      // plainly kept
        send_point(16'sd50, 16'sd50, 16'sd50, 1'b0);          // inside the robot
        send_point(16'sd50, 16'sd50, 16'sd120, 1'b0);         // over the robot, kept
        send_point(16'sd100, 16'sd0, 16'sd100, 1'b0);         // on the box edge
        send_point(16'sd101, 16'sd0, 16'sd100, 1'b0);         // just off it
        send_point(16'sd3000, 16'sd0, 16'sd100, 1'b0);        // range edge
        send_point(16'sd3001, 16'sd0, 16'sd100, 1'b0);
        send_point(-16'sd1000, -16'sd1, 16'sd30, 1'b0);       // height edge, az near -180
        send_point(-16'sd1000, 16'sd1, 16'sd29, 1'b0);
        send_point(16'sd0, -16'sd2000, 16'sd150, 1'b0);
        send_point(16'sd0, 16'sd2000, 16'sd151, 1'b1);        // end of cloud
        send_point(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 16'sd0, 1'b0);
        send_point(16'sd32767, -16'sd32768, -16'sd1, 1'b1);
        stop_sending();
        wait_idle();

        // spare indexes must not disturb anything; then an inverted range
        write_reg(CFG_SPARE_FIRST, {$urandom, $urandom});
        write_reg(CFG_SPARE_LAST, '1);
        load_bounds(2000, 1000, -1800, 1800, 30, 150,
                    xy_box_of(-100, 100, -100, 100), z_box_of(-100, 100));
        send_point(16'sd1500, 16'sd0, 16'sd100, 1'b0);
        send_point(16'sd1000, 16'sd200, 16'sd100, 1'b0);
        stop_sending();
        wait_idle();

        // inverted azimuth, then inverted height
        load_bounds(0, 3000, 900, -900, 30, 150,
                    xy_box_of(-100, 100, -100, 100), z_box_of(-100, 100));
        send_point(16'sd1000, 16'sd0, 16'sd100, 1'b0);
        stop_sending();
        wait_idle();
        load_bounds(0, 3000, -1800, 1800, 150, 30,
                    xy_box_of(-100, 100, -100, 100), z_box_of(-100, 100));
        send_point(16'sd1000, 16'sd0, 16'sd100, 1'b1);
        stop_sending();
        wait_idle();

        // --- random words, three idle modes, four bound settings each ---
        for (int m = 0; m < 3; m++)
        begin
            tx_idle_pct = idle_tx[m];
            rx_idle_pct = idle_rx[m];
            for (int k = 0; k < 4; k++)
            begin
                case (k)
                    0:
                        load_bounds(0, 3000, -1800, 1800, 30, 150,
                                    xy_box_of(-100, 100, -100, 100), z_box_of(-100, 100));
                    3:
                    begin
                        // widest bounds, box registers with arbitrary bits
                        load_bounds(0, 46341, -1800, 1800, -32768, 32767,
                                    {$urandom, $urandom}, $urandom);
                    end
                    default:
                    begin
                        // occasionally inverted by chance, which is fine
                        rlo = $urandom_range(1500);
                        rhi = $urandom_range(6000, 1000);
                        load_bounds(rlo, rhi,
                                    int'($urandom_range(2400)) - 1800,
                                    int'($urandom_range(2400)) - 600,
                                    int'($urandom_range(1500)) - 1000,
                                    int'($urandom_range(2500)) - 500,
                                    xy_box_of(-int'($urandom_range(600, 20)),
                                              $urandom_range(600, 20),
                                              -int'($urandom_range(600, 20)),
                                              $urandom_range(600, 20)),
                                    z_box_of(-int'($urandom_range(300, 20)),
                                             $urandom_range(300, 20)));
                    end
                endcase
                for (int n = 0; n < RANDOM_PER_SETTING; n++)
                begin
                    p = random_point();
                    send_point(p.x, p.y, p.z, p.last);
                end
                stop_sending();
                wait_idle();
            end
        end

        sb.check_drained();
        if (sb.errors == 0)
            $display("lidar_point_range_crop_filter test passed");
        else
            $display("lidar_point_range_crop_filter test failed");
        $finish;
    end

endmodule
